@@ rtl/dmajd_pkg.sv @@
// ----------------------------------------------------------------------------
// Dual moving average jump detector package
// Shared widths, reset values, register indexes and pipeline depth.
// ----------------------------------------------------------------------------
package dmajd_pkg;

  // Sample and threshold widths are fixed by the sensor data format.
  localparam int unsigned SampleW = 16;
  localparam int unsigned ThreshW = 16;

  // Default number of samples in each averaging window.
  localparam int unsigned WindowDefault = 10;

  // Threshold reset values.
  localparam logic [ThreshW-1:0] VocThreshReset = 16'd1200;
  localparam logic [ThreshW-1:0] NoxThreshReset = 16'd500;

  // Configuration register indexes.
  localparam int unsigned CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] CfgVocThreshold = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgNoxThreshold = 1'd1;

  // Number of pipeline slots an item can occupy, output register included.
  localparam int unsigned PipeDepth = 4;

endpackage

@@ rtl/dual_moving_average_jump_detector.sv @@
// A beat accepted at the input passes the stage 1, stage 2 and stage 3 registers and then the output register.
// Throughput: one beat per cycle while the output is not stalled; the sample memory takes one write and two
// reads per cycle, and the running sums advance once per beat.
// Stalls on the output fill the four pipeline slots before in_ready_o drops.
// Reset clears all control state and the fill count at once; window slots not
// yet written count as zero through the fill count, so no clearing pass is needed after reset.
// ----------------------------------------------------------------------------
// Dual moving average jump detector
// Keeps a window of VOC and NOx samples in a circular memory, tracks running
// sums, forms floor averages and flags deviations beyond programmable limits.
// ----------------------------------------------------------------------------
module dual_moving_average_jump_detector
  import dmajd_pkg::*;
#(
  parameter int unsigned Window = WindowDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // Sample input channel
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [SampleW-1:0] voc_sample_i,
  input  logic [SampleW-1:0] nox_sample_i,
  // Result output channel
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               voc_jump_o,
  output logic               nox_jump_o,
  // Configuration write channel
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [ThreshW-1:0] cfg_data_i
);

  // Derived widths and the exact reciprocal used for the division by Window.
  localparam int unsigned AddrW  = $clog2(Window);
  localparam int unsigned CntW   = $clog2(Window + 1);
  localparam int unsigned SumW   = $clog2(Window * ((1 << SampleW) - 1) + 1);
  localparam int unsigned DivK   = SumW + $clog2(Window);
  localparam longint unsigned DivM = ((64'd1 << DivK) + Window - 1) / Window;
  localparam int unsigned MulW   = $clog2(DivM + 1);
  localparam int unsigned ProdW  = (SumW + MulW > DivK + SampleW) ? SumW + MulW
                                                                  : DivK + SampleW;
  localparam logic [MulW-1:0]  DivMul   = MulW'(DivM);
  localparam logic [AddrW-1:0] LastAddr = AddrW'(Window - 1);
  localparam logic [CntW-1:0]  FullCnt  = CntW'(Window);
  localparam logic [CntW-1:0]  NextCnt  = CntW'(Window - 1);

  // Handshake and stage valids.
  logic in_acc;
  logic v1_q, v2_q, v3_q, out_valid_q;
  logic adv1, adv2, adv3;
  logic s1_free, s2_free, s3_free, out_free;

  // Threshold registers.
  logic [ThreshW-1:0] voc_th_q, nox_th_q;

  // Circular window memory, pointer and fill count.
  logic [2*SampleW-1:0] win_mem_q [Window];
  logic [AddrW-1:0]     wr_ptr_q, wr_ptr_d, nxt_ptr;
  logic [CntW-1:0]      fill_q;

  // Stage 1: memory read data and the new samples.
  logic [2*SampleW-1:0] old_rd_q, next_rd_q;
  logic [SampleW-1:0]   voc1_q, nox1_q;
  logic                 old_ok1_q, next_ok1_q;
  logic [SampleW-1:0]   voc_old, nox_old;
  logic [SumW-1:0]      voc_sum_q, nox_sum_q, voc_sum_d, nox_sum_d;

  // Stage 2: updated sums and samples.
  logic [SampleW-1:0] voc2_q, nox2_q;
  logic               chk2_q;
  logic [ProdW-1:0]   voc_prod, nox_prod;

  // Stage 3: averages and samples.
  logic [SampleW-1:0] voc3_q, nox3_q, voc_avg3_q, nox_avg3_q;
  logic               chk3_q;
  logic [SampleW-1:0] voc_dev, nox_dev;

  // Output flags, which also serve as the held flags.
  logic voc_flag_q, nox_flag_q;

  // Pipeline flow: each slot moves when the next one is free or moving.
  assign out_free   = !out_valid_q || out_ready_i;
  assign adv3       = v3_q && out_free;
  assign s3_free    = !v3_q || adv3;
  assign adv2       = v2_q && s3_free;
  assign s2_free    = !v2_q || adv2;
  assign adv1       = v1_q && s2_free;
  assign s1_free    = !v1_q || adv1;
  assign in_ready_o = s1_free;
  assign in_acc     = in_valid_i && s1_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_free) begin
        v1_q <= in_acc;
      end
      if (s2_free) begin
        v2_q <= adv1;
      end
      if (s3_free) begin
        v3_q <= adv2;
      end
      if (out_free) begin
        out_valid_q <= adv3;
      end
    end
  end

  // Configuration writes; unknown indexes are ignored.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      voc_th_q <= VocThreshReset;
      nox_th_q <= NoxThreshReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgVocThreshold: voc_th_q <= cfg_data_i;
        CfgNoxThreshold: nox_th_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // Write pointer wraps at Window; the read for the next-oldest slot is one ahead.
  assign wr_ptr_d = (wr_ptr_q == LastAddr) ? '0 : wr_ptr_q + 1'b1;
  assign nxt_ptr  = wr_ptr_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      fill_q   <= '0;
    end else if (in_acc) begin
      wr_ptr_q <= wr_ptr_d;
      if (fill_q != FullCnt) begin
        fill_q <= fill_q + 1'b1;
      end
    end
  end

  // Window memory: the oldest sample is read and replaced in the same cycle,
  // and the next-oldest one is read alongside it.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      win_mem_q[wr_ptr_q] <= {voc_sample_i, nox_sample_i};
      old_rd_q            <= win_mem_q[wr_ptr_q];
      next_rd_q           <= win_mem_q[nxt_ptr];
    end
  end

  // Stage 1 capture. Slots not yet written count as zero through the fill count.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      voc1_q     <= voc_sample_i;
      nox1_q     <= nox_sample_i;
      old_ok1_q  <= (fill_q == FullCnt);
      next_ok1_q <= (fill_q >= NextCnt);
    end
  end

  // Running sums drop the oldest sample and add the new one.
  assign voc_old   = old_ok1_q ? old_rd_q[2*SampleW-1:SampleW] : '0;
  assign nox_old   = old_ok1_q ? old_rd_q[SampleW-1:0] : '0;
  assign voc_sum_d = voc_sum_q + SumW'(voc1_q) - SumW'(voc_old);
  assign nox_sum_d = nox_sum_q + SumW'(nox1_q) - SumW'(nox_old);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      voc_sum_q <= '0;
      nox_sum_q <= '0;
    end else if (adv1) begin
      voc_sum_q <= voc_sum_d;
      nox_sum_q <= nox_sum_d;
    end
  end

  // Stage 2 capture. The flags update only when the next-oldest VOC sample is nonzero.
  always_ff @(posedge clk_i) begin
    if (adv1) begin
      voc2_q <= voc1_q;
      nox2_q <= nox1_q;
      chk2_q <= next_ok1_q && (next_rd_q[2*SampleW-1:SampleW] != '0);
    end
  end

  // Floor division by Window as a multiply by an exact reciprocal. While an
  // item sits in stage 2 the sum registers hold exactly its sums.
  assign voc_prod = ProdW'(voc_sum_q) * ProdW'(DivMul);
  assign nox_prod = ProdW'(nox_sum_q) * ProdW'(DivMul);

  always_ff @(posedge clk_i) begin
    if (adv2) begin
      voc3_q     <= voc2_q;
      nox3_q     <= nox2_q;
      chk3_q     <= chk2_q;
      voc_avg3_q <= voc_prod[DivK +: SampleW];
      nox_avg3_q <= nox_prod[DivK +: SampleW];
    end
  end

  // Absolute deviation of each average from its new sample.
  assign voc_dev = (voc_avg3_q > voc3_q) ? voc_avg3_q - voc3_q : voc3_q - voc_avg3_q;
  assign nox_dev = (nox_avg3_q > nox3_q) ? nox_avg3_q - nox3_q : nox3_q - nox_avg3_q;

  // Output flags hold their value unless the check is enabled.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      voc_flag_q <= 1'b0;
      nox_flag_q <= 1'b0;
    end else if (adv3 && chk3_q) begin
      voc_flag_q <= (voc_dev > voc_th_q);
      nox_flag_q <= (nox_dev > nox_th_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign voc_jump_o  = voc_flag_q;
  assign nox_jump_o  = nox_flag_q;

endmodule

@@ rtl/dmajd_checker.sv @@
// ----------------------------------------------------------------------------
// Dual moving average jump detector port checker
// Watches the top-level ports for output protocol and beat accounting.
// ----------------------------------------------------------------------------
module dmajd_checker
  import dmajd_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic [SampleW-1:0] voc_sample_i,
  input logic [SampleW-1:0] nox_sample_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic               voc_jump_o,
  input logic               nox_jump_o,
  input logic               cfg_valid_i,
  input logic               cfg_ready_o,
  input logic [CfgIdxW-1:0] cfg_index_i,
  input logic [ThreshW-1:0] cfg_data_i
);

  localparam int unsigned PendW = $clog2(PipeDepth + 2);
  localparam logic [PendW-1:0] PendMax = PendW'(PipeDepth);

  logic             in_acc, out_acc;
  logic [PendW-1:0] pend_q;

  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;

  // Count of beats accepted but not yet delivered.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else if (in_acc && !out_acc) begin
      pend_q <= pend_q + 1'b1;
    end else if (out_acc && !in_acc) begin
      pend_q <= pend_q - 1'b1;
    end
  end

  // A waiting result stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result withdrawn while stalled");

  // A waiting result keeps its flags.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(voc_jump_o) && $stable(nox_jump_o))
    else $error("result flags changed while stalled");

  // Every delivered result belongs to an accepted beat.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pend_q != '0)
    else $error("result offered with no beat outstanding");

  // The pipeline never holds more beats than it has slots.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= PendMax)
    else $error("more beats outstanding than pipeline slots");

  // A full pipeline must refuse new input.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q == PendMax && !out_ready_i |-> !in_ready_o)
    else $error("input accepted with pipeline full");

endmodule

bind dual_moving_average_jump_detector dmajd_checker u_dmajd_checker (.*);

@@ dv/dmajd_flag_checker.sv @@
// ----------------------------------------------------------------------------
// Dual moving average jump detector flag checker
// Watches the sample, result and configuration channels. Every accepted
// sample beat is run through a local model of both averaging windows to
// work out the jump flags. Every result beat is compared with the oldest
// flags still waiting.
// ----------------------------------------------------------------------------
module dmajd_flag_checker
  import dmajd_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  // Sample input channel
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic [SampleW-1:0] voc_sample_i,
  input  logic [SampleW-1:0] nox_sample_i,
  // Result output channel
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic               voc_jump_i,
  input  logic               nox_jump_i,
  // Configuration write channel
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [ThreshW-1:0] cfg_data_i,
  // Status toward the testbench top
  output int unsigned        fail_count_o,
  output int unsigned        pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // A full window of 16-bit samples fits in 20 bits at the default size.
  localparam int unsigned SumW  = SampleW + $clog2(WindowDefault);
  localparam int unsigned ChVoc = 0;
  localparam int unsigned ChNox = 1;
  localparam int unsigned NumCh = 2;

  typedef struct packed {
    logic voc_jump;
    logic nox_jump;
  } jump_flags_t;

  // Local copy of the detector state, indexed by channel.
  logic [SampleW-1:0] window_q [NumCh][WindowDefault];
  logic [SumW-1:0]    sum_q    [NumCh];
  logic [ThreshW-1:0] thresh_q [NumCh];
  logic               held_q   [NumCh];

  // Flags expected on the result channel, oldest first.
  jump_flags_t flags_q [$];
  int unsigned fails = 0;

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
  end

  // Return every window, sum, held flag and threshold to its reset value.
  task automatic clear_detector();
    int unsigned ch;
    int unsigned k;
    for (ch = 0; ch < NumCh; ch++) begin
      for (k = 0; k < WindowDefault; k++) begin
        window_q[ch][k] = '0;
      end
      sum_q[ch]  = '0;
      held_q[ch] = 1'b0;
    end
    thresh_q[ChVoc] = VocThreshReset;
    thresh_q[ChNox] = NoxThreshReset;
    flags_q.delete();
  endtask

  // Shift one sample into a channel window and return the floor average,
  // new sample included.
  task automatic shift_sample(input int unsigned ch, input logic [SampleW-1:0] sample,
                              output int unsigned avg);
    int unsigned k;
    sum_q[ch] = sum_q[ch] - SumW'(window_q[ch][0]) + SumW'(sample);
    for (k = 0; k < WindowDefault - 1; k++) begin
      window_q[ch][k] = window_q[ch][k+1];
    end
    window_q[ch][WindowDefault-1] = sample;
    avg = sum_q[ch] / WindowDefault;
  endtask

  // Advance both windows and queue the flags this sample beat must produce.
  // The flags are only re-evaluated when the oldest VOC sample left in the
  // window is nonzero; otherwise both keep their previous values.
  task automatic predict_flags(input logic [SampleW-1:0] voc, input logic [SampleW-1:0] nox);
    int unsigned        avg    [NumCh];
    logic [SampleW-1:0] sample [NumCh];
    int unsigned        dev;
    int unsigned        ch;
    sample[ChVoc] = voc;
    sample[ChNox] = nox;
    for (ch = 0; ch < NumCh; ch++) begin
      shift_sample(ch, sample[ch], avg[ch]);
    end
    if (window_q[ChVoc][0] != '0) begin
      for (ch = 0; ch < NumCh; ch++) begin
        dev = (avg[ch] > sample[ch]) ? avg[ch] - sample[ch] : sample[ch] - avg[ch];
        held_q[ch] = (dev > thresh_q[ch]);
      end
    end
    flags_q.push_back('{voc_jump: held_q[ChVoc], nox_jump: held_q[ChNox]});
  endtask

  // Sample all three channels at the clock edge at which beats complete.
  always @(posedge clk_i or negedge rst_ni) begin
    jump_flags_t want;
    if (!rst_ni) begin
      clear_detector();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CfgVocThreshold: thresh_q[ChVoc] = cfg_data_i;
          CfgNoxThreshold: thresh_q[ChNox] = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        predict_flags(voc_sample_i, nox_sample_i);
      end
      if (out_valid_i && out_ready_i) begin
        if (flags_q.size() == 0) begin
          $error("Result beat with nothing expected: voc_jump=%0b nox_jump=%0b",
                 voc_jump_i, nox_jump_i);
          fails++;
        end else begin
          want = flags_q.pop_front();
          if (voc_jump_i !== want.voc_jump) begin
            $error("voc_jump mismatch: expected %0b, actual %0b", want.voc_jump, voc_jump_i);
            fails++;
          end
          if (nox_jump_i !== want.nox_jump) begin
            $error("nox_jump mismatch: expected %0b, actual %0b", want.nox_jump, nox_jump_i);
            fails++;
          end
        end
      end
    end
    fail_count_o <= fails;
    pending_o    <= flags_q.size();
  end

endmodule

@@ dv/tb_dual_moving_average_jump_detector.sv @@
// ----------------------------------------------------------------------------
// Dual moving average jump detector testbench
// Drives sample beats and threshold writes into the detector, with random
// gaps and stalls on both channels, and leaves prediction and comparison
// to the flag checker beside the block. A directed opening covers window
// fill, held flags, equal deviation, zero thresholds and sample extremes;
// random phases with fresh thresholds follow.
// ----------------------------------------------------------------------------
module tb_dual_moving_average_jump_detector
  import dmajd_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned NumPhases   = 8;
  localparam int unsigned PhaseItems  = 100;
  localparam int unsigned HoldOffLen  = 150;
  localparam int unsigned SampleMax   = 65535;

  logic               clk_i        = 1'b0;
  logic               rst_ni       = 1'b0;
  logic               in_valid_i   = 1'b0;
  logic               in_ready_o;
  logic [SampleW-1:0] voc_sample_i = '0;
  logic [SampleW-1:0] nox_sample_i = '0;
  logic               out_valid_o;
  logic               out_ready_i  = 1'b0;
  logic               voc_jump_o;
  logic               nox_jump_o;
  logic               cfg_valid_i  = 1'b0;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i  = CfgVocThreshold;
  logic [ThreshW-1:0] cfg_data_i   = '0;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned cycle_count = 0;

  // Gap bounds per beat for each side, and a one-shot long stall request.
  int unsigned src_gap_max  = 0;
  int unsigned sink_gap_max = 0;
  int unsigned sink_hold    = 0;

  // Per-phase signal levels around which the steady samples wander.
  int voc_base = 1000;
  int nox_base = 400;

  dual_moving_average_jump_detector dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .voc_sample_i (voc_sample_i),
    .nox_sample_i (nox_sample_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .voc_jump_o   (voc_jump_o),
    .nox_jump_o   (nox_jump_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  dmajd_flag_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .voc_sample_i (voc_sample_i),
    .nox_sample_i (nox_sample_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .voc_jump_i   (voc_jump_o),
    .nox_jump_i   (nox_jump_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // 12 ns clock.
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Result side: random stall before each beat, or one long hold-off on
  // request while the sender keeps pushing samples.
  initial begin
    int unsigned stall;
    wait (rst_ni);
    forever begin
      if (sink_hold > 0) begin
        stall     = sink_hold;
        sink_hold = 0;
      end else begin
        stall = $urandom_range(0, sink_gap_max);
      end
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // Offer one sample beat after a random gap and wait until it is taken.
  // Valid stays high afterwards unless the next beat starts with a gap.
  task automatic send_sample(input logic [SampleW-1:0] voc, input logic [SampleW-1:0] nox);
    int unsigned gap;
    gap = $urandom_range(0, src_gap_max);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    voc_sample_i <= voc;
    nox_sample_i <= nox;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic send_run(input logic [SampleW-1:0] voc, input logic [SampleW-1:0] nox,
                          input int unsigned count);
    repeat (count) send_sample(voc, nox);
  endtask

  // Drop valid and wait until every result is back and the pipeline drained.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (PipeDepth + 2) @(posedge clk_i);
  endtask

  // Write both thresholds back to back; valid stays high between the beats.
  task automatic program_thresholds(input logic [ThreshW-1:0] voc_th,
                                    input logic [ThreshW-1:0] nox_th);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= CfgVocThreshold;
    cfg_data_i  <= voc_th;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_index_i <= CfgNoxThreshold;
    cfg_data_i  <= nox_th;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [SampleW-1:0] clamp_sample(input int value);
    if (value < 0) begin
      return '0;
    end
    if (value > int'(SampleMax)) begin
      return SampleW'(SampleMax);
    end
    return SampleW'(value);
  endfunction

  function automatic logic [ThreshW-1:0] pick_threshold();
    case ($urandom_range(0, 4))
      0: return '0;
      1: return '1;
      2: return ThreshW'($urandom_range(0, 200));
      3: return ThreshW'($urandom_range(200, 5000));
      default: return ThreshW'($urandom_range(0, SampleMax));
    endcase
  endfunction

  function automatic int unsigned pick_gap_max();
    case ($urandom_range(0, 2))
      0: return 0;
      1: return 2;
      default: return 7;
    endcase
  endfunction

  // Mostly steady levels with noise and occasional spikes, so the flags both
  // rise and fall; the rest is full-range noise, zero VOC and extremes.
  task automatic next_sample(output logic [SampleW-1:0] voc, output logic [SampleW-1:0] nox);
    int unsigned pick;
    int          sign;
    pick = $urandom_range(0, 99);
    sign = $urandom_range(0, 1) ? 1 : -1;
    if (pick < 50) begin
      voc = clamp_sample(voc_base + int'($urandom_range(0, 128)) - 64);
      nox = clamp_sample(nox_base + int'($urandom_range(0, 128)) - 64);
    end else if (pick < 65) begin
      voc = clamp_sample(voc_base + sign * int'($urandom_range(500, 20000)));
      nox = clamp_sample(nox_base - sign * int'($urandom_range(500, 20000)));
    end else if (pick < 85) begin
      voc = SampleW'($urandom_range(0, SampleMax));
      nox = SampleW'($urandom_range(0, SampleMax));
    end else if (pick < 95) begin
      voc = '0;
      nox = SampleW'($urandom_range(0, SampleMax));
    end else begin
      voc = $urandom_range(0, 1) ? '1 : '0;
      nox = $urandom_range(0, 1) ? '1 : '0;
    end
  endtask

  // Stimulus and verdict.
  initial begin
    logic [SampleW-1:0] voc;
    logic [SampleW-1:0] nox;
    int unsigned        phase;
    int unsigned        i;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: fill the window at reset thresholds; the first nine beats
    // see a reset zero in the oldest slot and must keep both flags low.
    src_gap_max  = 3;
    sink_gap_max = 3;
    send_run(16'd1000, 16'd400, 10);
    wait_idle();

    // A deviation of exactly the VOC threshold is no jump, while the NOx
    // deviation sits one above its threshold.
    program_thresholds(16'd1800, 16'd1799);
    send_sample(16'd3000, 16'd2400);
    // A zero VOC sample that later reaches the oldest slot holds both flags.
    send_sample(16'd0, 16'hFFFF);
    send_run(16'hFFFF, 16'd0, 9);
    wait_idle();

    // Zero thresholds: any nonzero deviation is a jump.
    program_thresholds(16'd0, 16'd0);
    send_sample(16'hFFFF, 16'hFFFF);
    send_sample(16'd1, 16'd1);
    wait_idle();

    // Random phases, each with fresh thresholds, levels and idling.
    for (phase = 0; phase < NumPhases; phase++) begin
      case (phase)
        0: program_thresholds('0, '1);
        1: program_thresholds('1, '0);
        default: program_thresholds(pick_threshold(), pick_threshold());
      endcase
      voc_base = $urandom_range(0, SampleMax);
      nox_base = $urandom_range(0, SampleMax);
      if (phase == 2) begin
        // Back-to-back samples against a long result stall fill the pipeline.
        src_gap_max  = 0;
        sink_gap_max = 0;
        sink_hold    = HoldOffLen;
      end else if (phase == 3) begin
        src_gap_max  = 7;
        sink_gap_max = 7;
      end else begin
        src_gap_max  = pick_gap_max();
        sink_gap_max = pick_gap_max();
      end
      for (i = 0; i < PhaseItems; i++) begin
        next_sample(voc, nox);
        send_sample(voc, nox);
      end
      wait_idle();
    end

    if (fail_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
